FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/swdhte_pkg.sv
// Types, codes and constants of the serial wire debug host transfer engine.
package swdhte_pkg;

  // Data word and its bit index
  localparam int DataBits = 32;
  localparam int DataIdxW = $clog2(DataBits);
  localparam int CntW     = 8;

  // Fixed phase lengths
  localparam logic [CntW-1:0] ReqLen  = CntW'(8);
  localparam logic [CntW-1:0] AckLen  = CntW'(3);
  localparam logic [CntW-1:0] DataLen = CntW'(DataBits + 1);

  // Operation codes
  localparam logic [1:0] OpTick      = 2'd0;
  localparam logic [1:0] OpTransfer  = 2'd1;
  localparam logic [1:0] OpLineReset = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgResetHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPostIdle  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTrailer   = 2'd2;

  // Acknowledge patterns, first sampled bit in bit 0
  localparam logic [2:0] AckOk    = 3'b001;
  localparam logic [2:0] AckWait  = 3'b010;
  localparam logic [2:0] AckFault = 3'b100;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhRstHigh = 4'd1,
    PhRstIdle = 4'd2,
    PhReq     = 4'd3,
    PhTrnAck  = 4'd4,
    PhAck     = 4'd5,
    PhTrnW    = 4'd6,
    PhWdata   = 4'd7,
    PhRdata   = 4'd8,
    PhTrnR    = 4'd9,
    PhTrail   = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StWait     = 3'd1,
    StFault    = 3'd2,
    StProtocol = 3'd3,
    StParity   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] reset_high_cycles;
    logic [3:0] post_reset_idle_cycles;
    logic [7:0] trailer_idle_cycles;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic                is_read;
    logic                access_port;
    logic [1:0]          reg_addr;
    logic [DataBits-1:0] write_data;
    logic                line_in;
  } in_item_t;

  typedef struct packed {
    logic                line_out;
    logic                line_drive;
    logic                ready_res;
    logic                done_res;
    logic [2:0]          status;
    logic [DataBits-1:0] read_data;
  } out_item_t;

endpackage

FILE: design/swdhte_cfg_regs.sv
// Configuration registers of the transfer engine.
module swdhte_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swdhte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swdhte_pkg::CfgDataW-1:0] cfg_data_i,
  output swdhte_pkg::cfg_t              cfg_o
);
  import swdhte_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgResetHigh: cfg_d.reset_high_cycles      = cfg_data_i;
        CfgPostIdle:  cfg_d.post_reset_idle_cycles = cfg_data_i[3:0];
        CfgTrailer:   cfg_d.trailer_idle_cycles    = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_high_cycles      <= 8'd50;
      cfg_q.post_reset_idle_cycles <= 4'd2;
      cfg_q.trailer_idle_cycles    <= 8'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/swdhte_in_reg.sv
// Input register stage holding one accepted item.
module swdhte_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  swdhte_pkg::in_item_t data_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output swdhte_pkg::in_item_t data_o
);
  import swdhte_pkg::*;

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     load;

  // Take a new item when empty or when the held item moves on
  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/swdhte_engine.sv
// Protocol state and one-period step logic of the transfer engine.
module swdhte_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  swdhte_pkg::in_item_t  item_i,
  input  swdhte_pkg::cfg_t      cfg_i,
  output swdhte_pkg::out_item_t result_o
);
  import swdhte_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DataBits-1:0] shift_q, shift_d;
  logic                par_q, par_d;
  logic [2:0]          ack_q, ack_d;
  logic [3:0]          req_q, req_d;
  status_e             st_q, st_d;

  logic                lo, drv, rdy, done;
  logic [CntW-1:0]     cnt_inc;

  // Length of a phase in periods, live configuration
  function automatic logic [CntW-1:0] phase_len(phase_e ph, cfg_t cfg);
    logic [CntW-1:0] len;
    case (ph)
      PhRstHigh: len = cfg.reset_high_cycles;
      PhRstIdle: len = CntW'(cfg.post_reset_idle_cycles);
      PhReq:     len = ReqLen;
      PhAck:     len = AckLen;
      PhWdata:   len = DataLen;
      PhRdata:   len = DataLen;
      PhTrail:   len = cfg.trailer_idle_cycles;
      default:   len = CntW'(1);
    endcase
    return len;
  endfunction

  // Phase that follows a finished one
  function automatic phase_e phase_next(phase_e ph, logic rd, status_e st);
    phase_e nxt;
    case (ph)
      PhRstHigh: nxt = PhRstIdle;
      PhReq:     nxt = PhTrnAck;
      PhTrnAck:  nxt = PhAck;
      PhAck:     nxt = !rd ? PhTrnW : ((st == StOk) ? PhRdata : PhTrnR);
      PhTrnW:    nxt = (st == StOk) ? PhWdata : PhTrail;
      PhWdata:   nxt = PhTrail;
      PhRdata:   nxt = PhTrnR;
      PhTrnR:    nxt = PhTrail;
      default:   nxt = PhIdle;
    endcase
    return nxt;
  endfunction

  // Step over phases configured to zero length
  function automatic phase_e skip_empty(phase_e ph, cfg_t cfg);
    phase_e p;
    p = ph;
    if (p == PhRstHigh && cfg.reset_high_cycles == '0) begin
      p = PhRstIdle;
    end
    if (p == PhRstIdle && cfg.post_reset_idle_cycles == '0) begin
      p = PhIdle;
    end
    if (p == PhTrail && cfg.trailer_idle_cycles == '0) begin
      p = PhIdle;
    end
    return p;
  endfunction

  // Work out one line period
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    par_d   = par_q;
    ack_d   = ack_q;
    req_d   = req_q;
    st_d    = st_q;
    lo      = 1'b0;
    drv     = 1'b1;
    done    = 1'b0;
    cnt_inc = '0;
    rdy     = (phase_q == PhIdle);

    // Start a new operation when idle
    if (rdy) begin
      if (item_i.operation == OpTransfer) begin
        req_d   = {item_i.reg_addr, item_i.is_read, item_i.access_port};
        shift_d = item_i.write_data;
        par_d   = 1'b0;
        ack_d   = '0;
        st_d    = StOk;
        phase_d = PhReq;
        cnt_d   = '0;
      end else if (item_i.operation == OpLineReset) begin
        req_d   = '0;
        st_d    = StOk;
        phase_d = skip_empty(PhRstHigh, cfg_i);
        cnt_d   = '0;
        if (phase_d == PhIdle) begin
          done = 1'b1;
        end
      end
    end

    if (phase_d != PhIdle) begin
      // Drive or sample the line for this phase
      case (phase_d)
        PhRstHigh: lo = 1'b1;
        PhReq: begin
          case (cnt_d)
            8'd0:    lo = 1'b1;
            8'd1:    lo = req_d[0];
            8'd2:    lo = req_d[1];
            8'd3:    lo = req_d[2];
            8'd4:    lo = req_d[3];
            8'd5:    lo = ^req_d;
            8'd6:    lo = 1'b0;
            default: lo = 1'b1;
          endcase
        end
        PhAck: begin
          drv = 1'b0;
          if (cnt_d < AckLen) begin
            ack_d[cnt_d[1:0]] = ack_d[cnt_d[1:0]] | item_i.line_in;
          end
        end
        PhWdata: begin
          if (cnt_d < CntW'(DataBits)) begin
            lo    = shift_d[cnt_d[DataIdxW-1:0]];
            par_d = par_d ^ lo;
          end else begin
            lo = par_d;
          end
        end
        PhRdata: begin
          drv = 1'b0;
          if (cnt_d < CntW'(DataBits)) begin
            shift_d[cnt_d[DataIdxW-1:0]] = shift_d[cnt_d[DataIdxW-1:0]] | item_i.line_in;
            par_d = par_d ^ item_i.line_in;
          end else if (par_d ^ item_i.line_in) begin
            st_d = StParity;
          end
        end
        PhTrnAck, PhTrnW, PhTrnR: drv = 1'b0;
        default: lo = 1'b0;
      endcase

      // Advance the bit counter and close the phase at its length
      cnt_inc = cnt_d + CntW'(1);
      if (cnt_inc >= phase_len(phase_d, cfg_i)) begin
        if (phase_d == PhAck) begin
          case (ack_d)
            AckOk:    st_d = StOk;
            AckWait:  st_d = StWait;
            AckFault: st_d = StFault;
            default:  st_d = StProtocol;
          endcase
          if (st_d == StOk && req_d[1]) begin
            shift_d = '0;
            par_d   = 1'b0;
          end
        end
        phase_d = skip_empty(phase_next(phase_d, req_d[1], st_d), cfg_i);
        cnt_d   = '0;
        if (phase_d == PhIdle) begin
          done = 1'b1;
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // Assemble the result of this period
  always_comb begin
    result_o            = '0;
    result_o.line_out   = lo;
    result_o.line_drive = drv;
    result_o.ready_res  = rdy;
    result_o.done_res   = done;
    if (done) begin
      result_o.status = st_d;
      if (st_d == StOk && req_d[1]) begin
        result_o.read_data = shift_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      shift_q <= '0;
      par_q   <= 1'b0;
      ack_q   <= '0;
      req_q   <= '0;
      st_q    <= StOk;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      par_q   <= par_d;
      ack_q   <= ack_d;
      req_q   <= req_d;
      st_q    <= st_d;
    end
  end

endmodule

FILE: design/swdhte_out_reg.sv
// Result register between the step logic and the output channel.
module swdhte_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  swdhte_pkg::out_item_t data_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output swdhte_pkg::out_item_t data_o
);
  import swdhte_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;
  logic      load;

  // Room when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !stall_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/swd_host_transfer_engine_core.sv
// Top level of the serial wire debug host transfer engine.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_data_i  (one line period)
//  out      output     out_valid_o / out_stall_i  out_data_o (one line result)
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per clock cycle while the output is not stalled; each item passes
// from input to output through the input register and then the result register.
// The step logic is one pass over the phase state between those registers.
// Reset clears the protocol state and both valid flags, and returns the
// configuration to its default counts.
// A stall on the output holds the result and, once the input register is
// full, stalls the input in the same cycle.
module swd_host_transfer_engine_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  swdhte_pkg::in_item_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output swdhte_pkg::out_item_t           out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swdhte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swdhte_pkg::CfgDataW-1:0] cfg_data_i
);
  import swdhte_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t result;
  logic      item_valid;
  logic      res_ready;
  logic      step;

  // Step the engine when an item sits in the input register and there is room
  assign step = item_valid && res_ready;

  swdhte_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swdhte_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (item_valid),
    .take_i  (step),
    .data_o  (item)
  );

  swdhte_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  swdhte_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .ready_o (res_ready),
    .data_i  (result),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

FILE: design/swdhte_checker.sv
// Port-level checks of the transfer engine and their binding to the top level.
`include "assert_macros.svh"

module swdhte_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input swdhte_pkg::out_item_t out_data_o
);
  import swdhte_pkg::*;

  logic released;
  logic mid_period;
  logic out_blank;
  logic err_word;
  logic out_known;

  // Conditions seen on the result port
  assign released   = out_valid_o && !out_data_o.line_drive;
  assign mid_period = out_valid_o && !out_data_o.done_res;
  assign out_blank  = (out_data_o.status == StOk) && (out_data_o.read_data == '0);
  assign err_word   = (out_data_o.status != StOk) && (out_data_o.read_data != '0);
  assign out_known  = out_data_o.status inside {StOk, StWait, StFault, StProtocol, StParity};

  // A stalled result stays offered
  `ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")

  // A released line carries a low level
  `ASSERT_DEF(a_release_low, released |-> !out_data_o.line_out, "released line not low")

  // Status and read data are blank outside the final period
  `ASSERT_DEF(a_blank_not_done, mid_period |-> out_blank, "status or data outside done")

  // A failed transfer returns no word
  `ASSERT_DEF(a_no_data_on_error, out_valid_o |-> !err_word, "read data with error status")

  // Status is one of the defined codes
  `ASSERT_DEF(a_status_code, out_valid_o |-> out_known, "undefined status code")

endmodule

bind swd_host_transfer_engine_core swdhte_checker u_swdhte_checker (.*);

FILE: dv/swd_host_transfer_engine_core_test.sv
// Self-checking testbench for the serial wire debug host transfer engine core.
module swd_host_transfer_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import swdhte_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0]         OpSpare   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [2:0]         AckNone   = 3'b000;
  localparam logic [2:0]         AckAll    = 3'b111;

  // Line period offsets within a transfer, counted from the start period
  localparam int unsigned AckAt    = ReqLen + 1;
  localparam int unsigned RdataAt  = AckAt + AckLen;
  localparam int unsigned ParityAt = RdataAt + DataBits;

  localparam int unsigned RandomPeriods = 48;
  localparam int unsigned RandomPhases  = 4;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  swd_host_transfer_engine_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Engine state as the host sees it, advanced once per accepted line period
  cfg_t        eng_cfg    = '{8'd50, 4'd2, 8'd8};
  phase_e      eng_phase  = PhIdle;
  logic [7:0]  eng_count  = '0;
  logic [31:0] eng_shift  = '0;
  logic        eng_par    = 1'b0;
  logic [2:0]  eng_ack    = '0;
  logic [3:0]  eng_req    = '0;
  status_e     eng_status = StOk;

  in_item_t    pending_periods[$];
  out_item_t   due_results[$];
  int unsigned periods_queued = 0;
  int unsigned failures       = 0;
  int unsigned results_checked = 0;
  int unsigned done_by_status[8];

  function automatic logic [7:0] phase_length(phase_e p);
    case (p)
      PhRstHigh:        return eng_cfg.reset_high_cycles;
      PhRstIdle:        return {4'd0, eng_cfg.post_reset_idle_cycles};
      PhReq:            return ReqLen;
      PhAck:            return AckLen;
      PhWdata, PhRdata: return DataLen;
      PhTrail:          return eng_cfg.trailer_idle_cycles;
      default:          return 8'd1;
    endcase
  endfunction

  function automatic phase_e next_phase(phase_e p);
    case (p)
      PhRstHigh: return PhRstIdle;
      PhReq:     return PhTrnAck;
      PhTrnAck:  return PhAck;
      PhAck:     return !eng_req[1] ? PhTrnW : (eng_status == StOk ? PhRdata : PhTrnR);
      PhTrnW:    return eng_status == StOk ? PhWdata : PhTrail;
      PhWdata:   return PhTrail;
      PhRdata:   return PhTrnR;
      PhTrnR:    return PhTrail;
      default:   return PhIdle;
    endcase
  endfunction

  // Step over phases whose configured length is zero
  function automatic void skip_empty_phases();
    while (eng_phase != PhIdle && phase_length(eng_phase) == 8'd0)
      eng_phase = next_phase(eng_phase);
  endfunction

  // Advance the engine by one line period and return what it should drive
  function automatic out_item_t swd_period_step(in_item_t it);
    out_item_t r;
    logic      finished;
    r            = '0;
    r.line_drive = 1'b1;
    r.ready_res  = (eng_phase == PhIdle);
    finished     = 1'b0;

    // Latch a new operation only while idle
    if (r.ready_res) begin
      if (it.operation == OpTransfer) begin
        eng_req    = {it.reg_addr, it.is_read, it.access_port};
        eng_shift  = it.write_data;
        eng_par    = 1'b0;
        eng_ack    = '0;
        eng_status = StOk;
        eng_phase  = PhReq;
        eng_count  = '0;
      end else if (it.operation == OpLineReset) begin
        eng_req    = '0;
        eng_status = StOk;
        eng_phase  = PhRstHigh;
        eng_count  = '0;
        skip_empty_phases();
        if (eng_phase == PhIdle) finished = 1'b1;
      end
    end

    if (eng_phase != PhIdle) begin
      // Drive or sample the line for this period
      case (eng_phase)
        PhRstHigh: r.line_out = 1'b1;
        PhReq: begin
          case (eng_count)
            8'd0:    r.line_out = 1'b1;
            8'd1:    r.line_out = eng_req[0];
            8'd2:    r.line_out = eng_req[1];
            8'd3:    r.line_out = eng_req[2];
            8'd4:    r.line_out = eng_req[3];
            8'd5:    r.line_out = ^eng_req;
            8'd6:    r.line_out = 1'b0;
            default: r.line_out = 1'b1;
          endcase
        end
        PhAck: begin
          r.line_drive = 1'b0;
          if (eng_count < AckLen) eng_ack = eng_ack | (3'(it.line_in) << eng_count);
        end
        PhWdata: begin
          if (eng_count < DataBits) begin
            r.line_out = eng_shift[eng_count[4:0]];
            eng_par    = eng_par ^ r.line_out;
          end else begin
            r.line_out = eng_par;
          end
        end
        PhRdata: begin
          r.line_drive = 1'b0;
          if (eng_count < DataBits) begin
            eng_shift = eng_shift | (32'(it.line_in) << eng_count);
            eng_par   = eng_par ^ it.line_in;
          end else if (eng_par ^ it.line_in) begin
            eng_status = StParity;
          end
        end
        PhTrnAck, PhTrnW, PhTrnR: r.line_drive = 1'b0;
        default: ;
      endcase

      // Advance the bit counter and move on when the phase is complete
      eng_count = eng_count + 8'd1;
      if (eng_count >= phase_length(eng_phase)) begin
        if (eng_phase == PhAck) begin
          case (eng_ack)
            AckOk:    eng_status = StOk;
            AckWait:  eng_status = StWait;
            AckFault: eng_status = StFault;
            default:  eng_status = StProtocol;
          endcase
          if (eng_status == StOk && eng_req[1]) begin
            eng_shift = '0;
            eng_par   = 1'b0;
          end
        end
        eng_phase = next_phase(eng_phase);
        eng_count = '0;
        skip_empty_phases();
        if (eng_phase == PhIdle) finished = 1'b1;
      end
    end

    if (finished) begin
      r.done_res = 1'b1;
      r.status   = eng_status;
      if (eng_status == StOk && eng_req[1]) r.read_data = eng_shift;
    end
    return r;
  endfunction

  // Sender: hold a stalled period, otherwise load the next after its gap
  logic        in_took   = 1'b0;
  logic        send_burst = 1'b0;
  int unsigned gap_left  = 0;

  always @(posedge clk_i) begin
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      due_results.push_back(swd_period_step(in_data_i));
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap_left <= send_burst ? 0 : $urandom_range(0, 16);
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (gap_left == 0 && pending_periods.size() != 0) begin
        in_data_i  <= pending_periods.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: compare each result with the oldest prediction
  logic        recv_burst = 1'b0;
  int unsigned stall_left = 0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %h", $time, out_data_o);
        failures++;
      end else begin
        want = due_results.pop_front();
        check_field("line_out", want.line_out, out_data_o.line_out);
        check_field("line_drive", want.line_drive, out_data_o.line_drive);
        check_field("ready_res", want.ready_res, out_data_o.ready_res);
        check_field("done_res", want.done_res, out_data_o.done_res);
        check_field("status", want.status, out_data_o.status);
        check_field("read_data", want.read_data, out_data_o.read_data);
        results_checked++;
        if (want.done_res) done_by_status[want.status]++;
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall_left <= recv_burst ? 0 : $urandom_range(0, 16);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk_i) out_stall_i <= (stall_left != 0);

  // Stimulus helpers
  function automatic in_item_t make_period(logic [1:0] op, logic lin);
    in_item_t it;
    it.operation   = op;
    it.is_read     = 1'($urandom);
    it.access_port = 1'($urandom);
    it.reg_addr    = 2'($urandom);
    it.write_data  = $urandom;
    it.line_in     = lin;
    return it;
  endfunction

  // Mostly plain ticks; the odd start or spare code must be ignored while busy
  function automatic in_item_t busy_period(logic lin);
    logic [1:0] op;
    op = ($urandom_range(0, 3) == 0) ? 2'($urandom) : OpTick;
    return make_period(op, lin);
  endfunction

  task automatic queue_period(in_item_t it);
    pending_periods.push_back(it);
    periods_queued++;
  endtask

  // Queue one whole transfer with the target answering on the line
  task automatic queue_transfer(in_item_t start, logic [2:0] ack, logic [31:0] word,
                                logic bad_parity);
    int unsigned span;
    logic        ok;
    logic        lin;
    ok   = (ack == AckOk);
    span = RdataAt + 1 + (ok ? DataLen : 0) + eng_cfg.trailer_idle_cycles;
    queue_period(start);
    for (int unsigned k = 1; k < span; k++) begin
      lin = 1'($urandom);
      if (k >= AckAt && k < RdataAt) lin = ack[k - AckAt];
      else if (ok && start.is_read && k >= RdataAt && k < ParityAt) lin = word[k - RdataAt];
      else if (ok && start.is_read && k == ParityAt) lin = ^word ^ bad_parity;
      queue_period(busy_period(lin));
    end
  endtask

  task automatic queue_line_reset();
    int unsigned span;
    span = eng_cfg.reset_high_cycles + eng_cfg.post_reset_idle_cycles;
    if (span == 0) span = 1;
    queue_period(make_period(OpLineReset, 1'($urandom)));
    for (int unsigned k = 1; k < span; k++) queue_period(busy_period(1'($urandom)));
  endtask

  // Wait until every queued period has been sent and its result checked
  task automatic wait_drained();
    while (pending_periods.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Hold the write until the block takes it, then mirror it in the shadow copy
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgResetHigh: eng_cfg.reset_high_cycles      = val;
      CfgPostIdle:  eng_cfg.post_reset_idle_cycles = val[3:0];
      CfgTrailer:   eng_cfg.trailer_idle_cycles    = val;
      default: ;
    endcase
  endtask

  task automatic cfg_apply(logic [7:0] high, logic [3:0] post, logic [7:0] trail);
    cfg_write(CfgResetHigh, high);
    cfg_write(CfgPostIdle, {4'($urandom), post});
    cfg_write(CfgTrailer, trail);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    in_item_t    start;
    int unsigned goal;
    int unsigned pick;
    logic [2:0]  ack;
    logic [31:0] word;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle ticks with the plain and the spare code, then reset settings
    queue_period(make_period(OpTick, 1'b1));
    queue_period(make_period(OpSpare, 1'b0));
    start             = make_period(OpTransfer, 1'b1);
    start.is_read     = 1'b0;
    start.access_port = 1'b1;
    start.reg_addr    = 2'd3;
    start.write_data  = '1;
    queue_transfer(start, AckOk, '0, 1'b0);
    start.is_read     = 1'b1;
    start.access_port = 1'b1;
    start.reg_addr    = 2'd2;
    queue_transfer(start, AckFault, '0, 1'b0);
    queue_line_reset();
    wait_drained();

    // All counts zero: empty line reset, zero trailer, wait and ok transfers, bad acks and parity
    cfg_write(CfgUnused, 8'hA5);
    cfg_apply(8'd0, 4'd0, 8'd0);
    queue_line_reset();
    start.is_read    = 1'b0;
    start.write_data = '0;
    queue_transfer(start, AckWait, '0, 1'b0);
    queue_transfer(start, AckOk, '0, 1'b0);
    start.is_read = 1'b1;
    queue_transfer(start, AckOk, '1, 1'b1);
    queue_transfer(start, AckNone, '0, 1'b0);
    queue_transfer(start, AckAll, '0, 1'b0);
    wait_drained();

    // All counts at their maximum
    cfg_apply(8'hFF, 4'hF, 8'hFF);
    queue_line_reset();
    queue_transfer(start, AckOk, $urandom, 1'b0);
    wait_drained();

    // Random phases of mostly well-formed transfers with random content
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      cfg_apply(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(50, 64)),
                4'($urandom),
                ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 40))
                                            : 8'($urandom_range(0, 10)));
      // Tick out whatever the last phase left in flight under the new counts
      while (eng_phase != PhIdle) begin
        queue_period(busy_period(1'($urandom)));
        wait_drained();
      end
      goal = periods_queued + RandomPeriods / RandomPhases;
      while (periods_queued < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          case ($urandom_range(0, 9))
            0:       ack = AckWait;
            1:       ack = AckFault;
            2:       ack = 3'($urandom);
            default: ack = AckOk;
          endcase
          case ($urandom_range(0, 9))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
          endcase
          queue_transfer(make_period(OpTransfer, 1'($urandom)), ack, word,
                         $urandom_range(0, 7) == 0);
        end else if (pick < 16) begin
          queue_line_reset();
        end else if (pick < 19) begin
          repeat ($urandom_range(1, 3))
            queue_period(make_period($urandom_range(0, 1) ? OpTick : OpSpare, 1'($urandom)));
        end else begin
          // Hold the sender until every result is back
          wait_drained();
        end
      end
      // Leave every other phase mid-operation so the next counts apply live
      if (ph % 2 == 1) begin
        queue_period(make_period($urandom_range(0, 1) ? OpTransfer : OpLineReset,
                                 1'($urandom)));
        repeat ($urandom_range(0, 20)) queue_period(busy_period(1'($urandom)));
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    $display("Checked %0d line periods; operations ended ok %0d, wait %0d, fault %0d,",
             results_checked, done_by_status[StOk], done_by_status[StWait],
             done_by_status[StFault]);
    $display("protocol error %0d, parity error %0d, over %0d random setting phases",
             done_by_status[StProtocol], done_by_status[StParity], RandomPhases);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", due_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
